@@ sv/sfr_pkg.sv @@
// Shared types and constants of the serial frame receiver.
// Depends on nothing; the deframer, result register, top level and testbench import it.
package sfr_pkg;

	localparam logic [7:0] HeadFirst  = 8'hFA;
	localparam logic [7:0] HeadSecond = 8'hAA;
	localparam logic [7:0] StuffByte  = 8'h00;
	localparam logic [7:0] MinLength  = 8'd5;

	typedef enum logic [2:0] {
		PH_HEAD1 = 3'd0,
		PH_HEAD2 = 3'd1,
		PH_ID    = 3'd2,
		PH_LEN   = 3'd3,
		PH_BODY  = 3'd4
	} hunt_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_frame_end;
		logic       frame_ok;
		logic [7:0] payload_count;
	} sfr_result_t;

endpackage

@@ sv/sfr_if.sv @@
// Valid/ready channels of the serial frame receiver: received bytes in, results out.
// Depends on nothing.
interface sfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_frame_end;
	logic       frame_ok;
	logic [7:0] payload_count;

	modport source (output valid, output data_byte, output is_frame_end,
		output frame_ok, output payload_count, input ready);
	modport sink (input valid, input data_byte, input is_frame_end,
		input frame_ok, input payload_count, output ready);
endinterface

@@ sv/sfr_deframer.sv @@
// Frame hunt state machine, checksum, destuffing and payload count.
// Depends on sfr_pkg.
module sfr_deframer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          frame_id,
	output logic                result_valid,
	output sfr_pkg::sfr_result_t result
);
	import sfr_pkg::*;

	hunt_phase_t phase_q, phase_d;
	logic [7:0]  pos_q, pos_d;
	logic [7:0]  exp_q, exp_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  prev_q, prev_d;
	logic [7:0]  prev2_q, prev2_d;
	logic [7:0]  emit_q, emit_d;

	logic [7:0] pos_inc;
	logic [7:0] sum_inc;
	logic       in_body;
	logic       drop;

	assign pos_inc = pos_q + 8'd1;
	assign sum_inc = sum_q + rx_byte;
	assign in_body = pos_inc < exp_q;
	assign drop    = (rx_byte == StuffByte) && (prev_q == HeadSecond) &&
		(prev2_q == HeadFirst);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				PH_HEAD2: phase_d = (rx_byte == HeadSecond) ? PH_ID : PH_HEAD1;
				PH_ID:    phase_d = (rx_byte == frame_id) ? PH_LEN : PH_HEAD1;
				PH_LEN:   phase_d = (rx_byte < MinLength) ? PH_HEAD1 : PH_BODY;
				PH_BODY:  phase_d = in_body ? PH_BODY : PH_HEAD1;
				default:  phase_d = (rx_byte == HeadFirst) ? PH_HEAD2 : PH_HEAD1;
			endcase
		end
	end

	// Frame counters, checksum, history and result.
	always_comb begin
		pos_d        = pos_q;
		exp_d        = exp_q;
		sum_d        = sum_q;
		prev_d       = prev_q;
		prev2_d      = prev2_q;
		emit_d       = emit_q;
		result_valid = 1'b0;
		result       = '0;
		if (accept) begin
			unique case (phase_q) inside
				PH_HEAD2, PH_ID: begin
					if ((phase_q == PH_HEAD2 && rx_byte == HeadSecond) ||
						(phase_q == PH_ID && rx_byte == frame_id)) begin
						pos_d = pos_inc;
						sum_d = sum_inc;
					end else begin
						pos_d   = '0;
						exp_d   = '0;
						sum_d   = '0;
						prev_d  = '0;
						prev2_d = '0;
						emit_d  = '0;
					end
				end
				PH_LEN: begin
					pos_d   = (rx_byte < MinLength) ? 8'd0 : pos_inc;
					sum_d   = (rx_byte < MinLength) ? 8'd0 : sum_inc;
					exp_d   = (rx_byte < MinLength) ? 8'd0 : rx_byte;
					prev_d  = '0;
					prev2_d = '0;
					emit_d  = '0;
				end
				PH_BODY: begin
					if (in_body) begin
						pos_d   = pos_inc;
						sum_d   = sum_inc;
						prev2_d = prev_q;
						prev_d  = rx_byte;
						if (!drop) begin
							emit_d           = emit_q + 8'd1;
							result_valid     = 1'b1;
							result.data_byte = rx_byte;
						end
					end else begin
						// The checksum byte closes the frame and restarts the hunt.
						result_valid         = 1'b1;
						result.is_frame_end  = 1'b1;
						result.frame_ok      = (sum_q == rx_byte);
						result.payload_count = emit_q;
						pos_d   = '0;
						exp_d   = '0;
						sum_d   = '0;
						prev_d  = '0;
						prev2_d = '0;
						emit_d  = '0;
					end
				end
				default: begin
					pos_d   = (rx_byte == HeadFirst) ? 8'd1 : 8'd0;
					sum_d   = (rx_byte == HeadFirst) ? HeadFirst : 8'd0;
					exp_d   = '0;
					prev_d  = '0;
					prev2_d = '0;
					emit_d  = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD1;
			pos_q   <= '0;
			exp_q   <= '0;
			sum_q   <= '0;
			prev_q  <= '0;
			prev2_q <= '0;
			emit_q  <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			exp_q   <= exp_d;
			sum_q   <= sum_d;
			prev_q  <= prev_d;
			prev2_q <= prev2_d;
			emit_q  <= emit_d;
		end
	end

	a_body_length: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> exp_q >= MinLength)
		else $error("body phase entered with a short frame length");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q <= pos_q)
		else $error("more payload bytes emitted than frame bytes received");

	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_frame_end |=> phase_q == PH_HEAD1 && pos_q == 8'd0)
		else $error("hunt did not restart after a frame end");

	a_result_phase: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> accept && phase_q == PH_BODY)
		else $error("result produced outside the frame body");

endmodule

@@ sv/sfr_out_stage.sv @@
// Result register between the deframer and the result channel.
// Depends on sfr_pkg and sfr_if.
module sfr_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  sfr_pkg::sfr_result_t result,
	output logic                can_take,
	sfr_res_if.source           res
);
	import sfr_pkg::*;

	logic        valid_s1;
	sfr_result_t result_s1;

	// A new beat may enter while the held one leaves in the same cycle.
	assign can_take = !valid_s1 || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (res.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s1 <= result;
		end
	end

	assign res.valid         = valid_s1;
	assign res.data_byte     = result_s1.data_byte;
	assign res.is_frame_end  = result_s1.is_frame_end;
	assign res.frame_ok      = result_s1.frame_ok;
	assign res.payload_count = result_s1.payload_count;

endmodule

@@ sv/serial_frame_receiver_top.sv @@
// Top level of the serial frame receiver: id register, deframer and result register.
// Depends on sfr_pkg, sfr_if, sfr_deframer and sfr_out_stage.
//
// Usage: received bytes arrive on the rx channel, one byte per beat. The block
// hunts for 0xFA 0xAA, the id held in frame_id, and a length byte giving the
// whole frame length including header and checksum. Body bytes appear on the
// res channel as payload beats; a 0x00 that follows 0xFA 0xAA in the body is
// dropped. The checksum byte yields one frame end beat with frame_ok and the
// payload count. Header bytes and dropped bytes produce no beat.
// The id register is written through cfg_we and cfg_wdata and resets to zero.
// Throughput is one byte per cycle while res takes its beats; a result appears on res
// in the cycle after its byte is accepted, from a single result register.
// If the result consumer stalls while a beat is held, rx ready drops until the
// held beat is taken; no beat is lost or repeated. Reset returns the hunt to
// waiting for the first header byte and empties the result register.
module serial_frame_receiver_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	sfr_rx_if.sink     rx,
	sfr_res_if.source  res
);
	import sfr_pkg::*;

	logic [7:0]  frame_id_q;
	logic        accept;
	logic        can_take;
	logic        result_valid;
	sfr_result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_id_q <= '0;
		end else if (cfg_we) begin
			frame_id_q <= cfg_wdata;
		end
	end

	assign rx.ready = can_take;
	assign accept   = rx.valid && can_take;

	sfr_deframer u_deframer (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.rx_byte      (rx.rx_byte),
		.frame_id     (frame_id_q),
		.result_valid (result_valid),
		.result       (result)
	);

	sfr_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (result_valid),
		.result   (result),
		.can_take (can_take),
		.res      (res)
	);

endmodule

@@ tb/serial_frame_receiver_top_test.sv @@
// Self-checking test of serial_frame_receiver_top: drives received bytes on the rx channel,
// predicts every payload and frame end beat, and checks them on the res channel.
// Depends on sfr_pkg, sfr_if and the serial_frame_receiver_top RTL.
module serial_frame_receiver_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sfr_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;

	sfr_rx_if  rx_ch();
	sfr_res_if res_ch();

	serial_frame_receiver_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_ch),
		.res       (res_ch)
	);

	// Deframer state as the testbench tracks it.
	hunt_phase_t m_phase;
	logic [7:0]  m_pos, m_len, m_sum, m_prev1, m_prev2, m_count, m_id;

	sfr_result_t pending_results[$];
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int bytes_sent = 0;
	int error_count = 0;
	int good_frames = 0;
	int bad_frames = 0;
	int payload_beats = 0;
	int id_writes = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		res_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic void clear_hunt();
		m_phase = PH_HEAD1;
		m_pos = 8'd0;
		m_len = 8'd0;
		m_sum = 8'd0;
		m_prev1 = 8'd0;
		m_prev2 = 8'd0;
		m_count = 8'd0;
	endfunction

	function automatic void advance_frame(input logic [7:0] b, input hunt_phase_t nxt);
		m_phase = nxt;
		m_pos = m_pos + 8'd1;
		m_sum = m_sum + b;
	endfunction

	// Returns 1 when the byte produces a beat on res, with that beat in r.
	function automatic bit predict_deframe(input logic [7:0] b, output sfr_result_t r);
		logic [7:0] pos;
		bit         drop;
		r = '0;
		predict_deframe = 1'b0;
		case (m_phase)
			PH_HEAD2: begin
				if (b == HeadSecond) advance_frame(b, PH_ID);
				else clear_hunt();
			end
			PH_ID: begin
				if (b == m_id) advance_frame(b, PH_LEN);
				else clear_hunt();
			end
			PH_LEN: begin
				if (b < MinLength) begin
					clear_hunt();
				end else begin
					m_len = b;
					advance_frame(b, PH_BODY);
					m_prev1 = 8'd0;
					m_prev2 = 8'd0;
					m_count = 8'd0;
				end
			end
			PH_BODY: begin
				pos = m_pos + 8'd1;
				if (pos < m_len) begin
					drop = (b == StuffByte) && (m_prev1 == HeadSecond) && (m_prev2 == HeadFirst);
					m_pos = pos;
					m_sum = m_sum + b;
					m_prev2 = m_prev1;
					m_prev1 = b;
					if (!drop) begin
						m_count = m_count + 8'd1;
						r.data_byte = b;
						predict_deframe = 1'b1;
					end
				end else begin
					r.is_frame_end = 1'b1;
					r.frame_ok = (m_sum == b);
					r.payload_count = m_count;
					clear_hunt();
					predict_deframe = 1'b1;
				end
			end
			default: begin
				clear_hunt();
				if (b == HeadFirst) advance_frame(b, PH_HEAD2);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		sfr_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected beat: data_byte %0h is_frame_end %0b", res_ch.data_byte,
					res_ch.is_frame_end);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (res_ch.data_byte !== want.data_byte) begin
					$error("data_byte: expected %0h, got %0h", want.data_byte, res_ch.data_byte);
					error_count++;
				end
				if (res_ch.is_frame_end !== want.is_frame_end) begin
					$error("is_frame_end: expected %0b, got %0b", want.is_frame_end,
						res_ch.is_frame_end);
					error_count++;
				end
				if (res_ch.frame_ok !== want.frame_ok) begin
					$error("frame_ok: expected %0b, got %0b", want.frame_ok, res_ch.frame_ok);
					error_count++;
				end
				if (res_ch.payload_count !== want.payload_count) begin
					$error("payload_count: expected %0d, got %0d", want.payload_count,
						res_ch.payload_count);
					error_count++;
				end
				if (!want.is_frame_end) payload_beats++;
				else if (want.frame_ok) good_frames++;
				else bad_frames++;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		sfr_result_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		if (predict_deframe(b, r)) pending_results.push_back(r);
		bytes_sent++;
	endtask

	// Stops sending and waits until every predicted beat has been seen.
	task automatic drain();
		rx_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_frame_id(input logic [7:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_id = v;
		id_writes++;
	endtask

	function automatic logic [7:0] pick_body_byte(input logic [7:0] p1, input logic [7:0] p2);
		int r;
		r = $urandom_range(99);
		if (p2 == HeadFirst && p1 == HeadSecond && r < 60) return StuffByte;
		if (p1 == HeadFirst && r < 50) return HeadSecond;
		if (r < 12) return HeadFirst;
		return 8'($urandom_range(255));
	endfunction

	// Sends a frame with a random body; cut_at >= 0 abandons it after that many bytes.
	task automatic send_frame(input logic [7:0] id_byte, input logic [7:0] len_byte,
			input bit bad_sum, input int cut_at);
		logic [7:0] frame_bytes[$];
		logic [7:0] sum, p1, p2, b;
		frame_bytes = {HeadFirst, HeadSecond, id_byte, len_byte};
		p1 = 8'd0;
		p2 = 8'd0;
		for (int k = 4; k < int'(len_byte) - 1; k++) begin
			b = pick_body_byte(p1, p2);
			frame_bytes.push_back(b);
			p2 = p1;
			p1 = b;
		end
		sum = 8'd0;
		foreach (frame_bytes[k]) sum = sum + frame_bytes[k];
		frame_bytes.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
		foreach (frame_bytes[k]) begin
			if (cut_at >= 0 && k >= cut_at) break;
			send_byte(frame_bytes[k]);
		end
	endtask

	task automatic test_header_hunt();
		send_byte(8'hFF);
		send_byte(StuffByte);
		// A second 0xFA where 0xAA belongs restarts the hunt and is not taken as a new header.
		send_byte(HeadFirst);
		send_byte(HeadFirst);
		send_byte(HeadSecond);
		send_byte(HeadFirst);
		send_byte(HeadSecond);
		send_byte(8'h5C);
		send_byte(HeadFirst);
		send_byte(HeadSecond);
		send_byte(m_id);
		send_byte(MinLength - 8'd1);
	endtask

	task automatic test_zero_payload();
		send_byte(HeadFirst);
		send_byte(HeadSecond);
		send_byte(m_id);
		send_byte(MinLength);
		send_byte(HeadFirst + HeadSecond + m_id + MinLength);
	endtask

	task automatic test_stuffing();
		logic [7:0] frame_bytes[$];
		logic [7:0] sum;
		set_frame_id(8'hFF);
		frame_bytes = {HeadFirst, HeadSecond, 8'hFF, 8'd9, HeadFirst, HeadSecond, StuffByte, 8'hFF};
		sum = 8'd0;
		foreach (frame_bytes[k]) begin
			sum = sum + frame_bytes[k];
			send_byte(frame_bytes[k]);
		end
		send_byte(sum);
	endtask

	task automatic test_id_change_mid_frame();
		send_byte(HeadFirst);
		send_byte(HeadSecond);
		set_frame_id(8'h37);
		send_byte(8'h37);
		send_byte(MinLength);
		send_byte((HeadFirst + HeadSecond + 8'h37 + MinLength) ^ 8'h01);
	endtask

	task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items,
			input logic [7:0] start_id, input bit with_max_frame);
		int stop_at, next_id_change, r, len;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		set_frame_id(start_id);
		stop_at = bytes_sent + n_items;
		next_id_change = bytes_sent + 180;
		if (with_max_frame) send_frame(m_id, 8'd255, 1'b0, -1);
		while (bytes_sent < stop_at) begin
			if (bytes_sent >= next_id_change) begin
				r = $urandom_range(3);
				set_frame_id(r == 0 ? HeadFirst : r == 1 ? HeadSecond : 8'($urandom_range(255)));
				next_id_change = bytes_sent + 180;
			end
			r = $urandom_range(99);
			len = $urandom_range(99) < 3 ? $urandom_range(130, 255) : $urandom_range(5, 24);
			if (r < 70) begin
				send_frame(m_id, 8'(len), $urandom_range(99) < 20, -1);
			end else if (r < 80) begin
				repeat ($urandom_range(1, 4))
					send_byte($urandom_range(3) == 0 ? HeadFirst : 8'($urandom_range(255)));
			end else if (r < 85) begin
				send_byte(HeadFirst);
				send_byte(8'($urandom_range(255)));
			end else if (r < 90) begin
				send_byte(HeadFirst);
				send_byte(HeadSecond);
				send_byte(m_id ^ 8'($urandom_range(1, 255)));
			end else if (r < 95) begin
				send_byte(HeadFirst);
				send_byte(HeadSecond);
				send_byte(m_id);
				send_byte(8'($urandom_range(0, 4)));
			end else begin
				// An abandoned frame: when it is cut after its length byte, the bytes that follow land in its body.
				send_frame(m_id, 8'(len), 1'b0, $urandom_range(1, len - 1));
			end
		end
	endtask

	initial begin
		m_id = 8'h00;
		clear_hunt();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_hunt();
		test_zero_payload();
		test_stuffing();
		test_id_change_mid_frame();
		test_random_traffic(37, 82, 550, 8'h00, 1'b0);
		test_random_traffic(82, 37, 550, 8'hFF, 1'b0);
		test_random_traffic(0, 0, 550, 8'($urandom_range(1, 254)), 1'b1);
		drain();
		repeat (10) @(posedge clk);
		$display("Sent %0d bytes with %0d id writes under three idling patterns.", bytes_sent,
			id_writes);
		$display("Checked %0d payload beats, %0d good frames and %0d bad frames.", payload_beats,
			good_frames, bad_frames);
		if (error_count == 0)
			$display("serial_frame_receiver_top_test: clean");
		else
			$display("serial_frame_receiver_top_test: errors");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("serial_frame_receiver_top_test: errors");
		$finish;
	end

endmodule

@@ files.f @@
sv/sfr_pkg.sv
sv/sfr_if.sv
sv/sfr_deframer.sv
sv/sfr_out_stage.sv
sv/serial_frame_receiver_top.sv
tb/serial_frame_receiver_top_test.sv
